FILE: hw/rtl/gcb_pkg.sv
// Shared types and constants for the glyph coverage blend block.
`default_nettype none

package gcb_pkg;

    // Glyph source pixel formats
    typedef enum logic [1:0] {
        MODE_MONO  = 2'd0,
        MODE_GRAY2 = 2'd1,
        MODE_LCD   = 2'd2,
        MODE_GRAY8 = 2'd3
    } mode_t;

    // Configuration register indexes
    localparam logic [2:0] REG_TEXT_RED    = 3'd0;
    localparam logic [2:0] REG_TEXT_GREEN  = 3'd1;
    localparam logic [2:0] REG_TEXT_BLUE   = 3'd2;
    localparam logic [2:0] REG_SOURCE_MODE = 3'd3;
    localparam logic [2:0] REG_DIM_ENABLE  = 3'd4;

    localparam logic [7:0] GRAY2_SCALE = 8'h55;
    localparam logic [7:0] COV_FULL    = 8'hff;
    localparam logic [7:0] COV_NONE    = 8'h00;

    // Active configuration
    typedef struct packed {
        logic [7:0] text_red;
        logic [7:0] text_green;
        logic [7:0] text_blue;
        mode_t      source_mode;
        logic       dim_enable;
    } cfg_t;

    // One input word as held in the input register
    typedef struct packed {
        logic [7:0] source_byte_a;
        logic [7:0] source_byte_b;
        logic [7:0] source_byte_c;
        logic [2:0] bit_offset;
        logic [7:0] dest_red;
        logic [7:0] dest_green;
        logic [7:0] dest_blue;
        logic       solid_fill;
    } pixel_t;

    // Per-channel coverage
    typedef struct packed {
        logic [7:0] cov_red;
        logic [7:0] cov_green;
        logic [7:0] cov_blue;
    } coverage_t;

endpackage

`default_nettype wire

FILE: hw/rtl/gcb_unpack.sv
// Unpacks glyph source bytes into per-channel coverage, with optional dimming.
`default_nettype none

module gcb_unpack (
    input  wire gcb_pkg::cfg_t      cfg,
    input  wire logic [7:0]         source_byte_a,
    input  wire logic [7:0]         source_byte_b,
    input  wire logic [7:0]         source_byte_c,
    input  wire logic [2:0]         bit_offset,
    output gcb_pkg::coverage_t      coverage
);

    logic       mono_bit;
    logic [1:0] gray_pair;
    logic [7:0] shifted;
    logic [7:0] cov_r;
    logic [7:0] cov_g;
    logic [7:0] cov_b;

    // Pick the mono bit and the 2-bit gray pair, most significant column first
    always_comb begin
        mono_bit  = source_byte_a[3'd7 - bit_offset];
        shifted   = source_byte_a >> {~bit_offset[1:0], 1'b0};
        gray_pair = shifted[1:0];
    end

    // Decode the source format
    always_comb begin
        cov_r = source_byte_a;
        cov_g = source_byte_a;
        cov_b = source_byte_a;
        unique case (cfg.source_mode)
            gcb_pkg::MODE_MONO: begin
                cov_r = mono_bit ? gcb_pkg::COV_FULL : gcb_pkg::COV_NONE;
                cov_g = cov_r;
                cov_b = cov_r;
            end
            gcb_pkg::MODE_GRAY2: begin
                cov_r = {6'd0, gray_pair} * gcb_pkg::GRAY2_SCALE;
                cov_g = cov_r;
                cov_b = cov_r;
            end
            gcb_pkg::MODE_LCD: begin
                cov_r = source_byte_a;
                cov_g = source_byte_b;
                cov_b = source_byte_c;
            end
            default: begin
                cov_r = source_byte_a;
                cov_g = source_byte_a;
                cov_b = source_byte_a;
            end
        endcase
    end

    // Halve coverage for dim text
    always_comb begin
        if (cfg.dim_enable) begin
            coverage.cov_red   = {1'b0, cov_r[7:1]};
            coverage.cov_green = {1'b0, cov_g[7:1]};
            coverage.cov_blue  = {1'b0, cov_b[7:1]};
        end else begin
            coverage.cov_red   = cov_r;
            coverage.cov_green = cov_g;
            coverage.cov_blue  = cov_b;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/gcb_blend.sv
// Blends one color channel from the destination toward the text color.
`default_nettype none

module gcb_blend (
    input  wire logic [7:0] dst,
    input  wire logic [7:0] col,
    input  wire logic [7:0] cov,
    output logic [7:0]      result
);

    logic signed [8:0]  diff;
    logic signed [17:0] prod;

    // Signed difference scaled by coverage; floor shift by 8 is the upper bits
    always_comb begin
        diff = $signed({1'b0, col}) - $signed({1'b0, dst});
        prod = 18'(diff) * $signed({10'd0, cov});
    end

    // Zero coverage keeps the destination, full coverage takes the color
    always_comb begin
        if (cov == gcb_pkg::COV_NONE) begin
            result = dst;
        end else if (cov == gcb_pkg::COV_FULL) begin
            result = col;
        end else begin
            result = dst + prod[15:8];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/glyph_coverage_blend_core.sv
// Top level of the glyph coverage blend block: registers, handshake and datapath.
//
// Per-pixel text compositor. Each input word on the s_ channel carries the glyph
// source bytes, the pixel column within a packed byte and the destination RGB
// pixel; s_tuser flags a solid-fill pixel that takes the text color outright.
// The m_ channel returns one blended RGB word for every input word, in order.
// Text color, source format and dimming are set through the write port
// (cfg_wen, cfg_addr, cfg_wdata); the user must write them only while no pixel is
// in flight, which the block does not enforce; unknown indexes are ignored.
// Pipeline: input register, then result register, with the unpack and blend
// logic between them.
// Throughput: one word per cycle while the receiver keeps m_tready high; the
// single combinational pass from the input register to the result register
// sets that figure.
// Reset (aresetn low, synchronous) empties both registers and restores the
// text color to white, the format to 8-bit gray and dimming to off.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more word; s_tready then drops until m_tready.
`default_nettype none

module glyph_coverage_blend_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port
    input  wire logic        cfg_wen,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [7:0]  cfg_wdata,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata fields from bit 0: source_byte_a[7:0], source_byte_b[15:8],
    // source_byte_c[23:16], bit_offset[26:24], dest_red[34:27],
    // dest_green[42:35], dest_blue[50:43], zero pad[55:51]
    input  wire logic [55:0] s_tdata,
    // s_tuser fields from bit 0: solid_fill[0]
    input  wire logic [0:0]  s_tuser,
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata fields from bit 0: out_red[7:0], out_green[15:8], out_blue[23:16]
    output logic [23:0]      m_tdata
);

    gcb_pkg::cfg_t      cfg_reg;
    gcb_pkg::pixel_t    pix_reg;
    gcb_pkg::coverage_t coverage;
    logic               in_valid_reg;
    logic               out_valid_reg;
    logic [23:0]        out_data_reg;
    logic               out_ready;
    logic               in_load;
    logic [7:0]         blend_red;
    logic [7:0]         blend_green;
    logic [7:0]         blend_blue;
    logic [23:0]        out_data_next;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.text_red    <= 8'hff;
            cfg_reg.text_green  <= 8'hff;
            cfg_reg.text_blue   <= 8'hff;
            cfg_reg.source_mode <= gcb_pkg::MODE_GRAY8;
            cfg_reg.dim_enable  <= 1'b0;
        end else if (cfg_wen) begin
            unique case (cfg_addr)
                gcb_pkg::REG_TEXT_RED:    cfg_reg.text_red   <= cfg_wdata;
                gcb_pkg::REG_TEXT_GREEN:  cfg_reg.text_green <= cfg_wdata;
                gcb_pkg::REG_TEXT_BLUE:   cfg_reg.text_blue  <= cfg_wdata;
                gcb_pkg::REG_SOURCE_MODE:
                    cfg_reg.source_mode <= gcb_pkg::mode_t'(cfg_wdata[1:0]);
                gcb_pkg::REG_DIM_ENABLE:  cfg_reg.dim_enable <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Handshake: each register advances when the one after it is free
    assign out_ready = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign in_load   = s_tvalid && s_tready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            pix_reg.source_byte_a <= s_tdata[7:0];
            pix_reg.source_byte_b <= s_tdata[15:8];
            pix_reg.source_byte_c <= s_tdata[23:16];
            pix_reg.bit_offset    <= s_tdata[26:24];
            pix_reg.dest_red      <= s_tdata[34:27];
            pix_reg.dest_green    <= s_tdata[42:35];
            pix_reg.dest_blue     <= s_tdata[50:43];
            pix_reg.solid_fill    <= s_tuser[0];
        end
    end

    // Unpack coverage
    gcb_unpack u_unpack (
        .cfg           (cfg_reg),
        .source_byte_a (pix_reg.source_byte_a),
        .source_byte_b (pix_reg.source_byte_b),
        .source_byte_c (pix_reg.source_byte_c),
        .bit_offset    (pix_reg.bit_offset),
        .coverage      (coverage)
    );

    // Blend each channel
    gcb_blend u_blend_red (
        .dst    (pix_reg.dest_red),
        .col    (cfg_reg.text_red),
        .cov    (coverage.cov_red),
        .result (blend_red)
    );

    gcb_blend u_blend_green (
        .dst    (pix_reg.dest_green),
        .col    (cfg_reg.text_green),
        .cov    (coverage.cov_green),
        .result (blend_green)
    );

    gcb_blend u_blend_blue (
        .dst    (pix_reg.dest_blue),
        .col    (cfg_reg.text_blue),
        .cov    (coverage.cov_blue),
        .result (blend_blue)
    );

    // Solid fill overrides the blend
    always_comb begin
        if (pix_reg.solid_fill) begin
            out_data_next = {cfg_reg.text_blue, cfg_reg.text_green, cfg_reg.text_red};
        end else begin
            out_data_next = {blend_blue, blend_green, blend_red};
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && in_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Reset empties the result register
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // An empty input register always takes a word
    assert property (@(posedge aclk) disable iff (!aresetn) !in_valid_reg |-> s_tready)
        else $error("input register empty but not ready");

    // A held word moves on into the result register when it is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_ready |=> m_tvalid)
        else $error("word lost between input and result register");

    // A stalled input word is kept
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_ready |=> in_valid_reg && $stable(pix_reg))
        else $error("stalled input word dropped");

endmodule

`default_nettype wire
